// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define V3N_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define V3N_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants of the vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

  localparam int TOL_W       = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic empty;
    logic full;
  } v3n_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/v3n_front.sv =====
// ----------------------------------------------------------------------------
// v3n_front
// Takes input beats, splits sign and magnitude, squares and sums them.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_front #(
  parameter int COMP_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [COMP_WIDTH-1:0]       in_comp_x,
  input  wire logic signed [COMP_WIDTH-1:0]       in_comp_y,
  input  wire logic signed [COMP_WIDTH-1:0]       in_comp_z,
  input  wire v3n_pkg::v3n_qstat_t                qstat,
  output logic                                    push,
  output logic [3+5*COMP_WIDTH-1:0]               push_data
);

  localparam int W  = COMP_WIDTH;
  localparam int SW = 2 * W;

  logic              en;
  logic [W-1:0]      abs_nxt [3];
  logic [2:0]        neg_nxt;

  logic              s1_v_r;
  logic [2:0]        s1_neg_r;
  logic [W-1:0]      s1_mag_r [3];
  logic              s2_v_r;
  logic [2:0]        s2_neg_r;
  logic [W-1:0]      s2_mag_r [3];
  logic [SW-1:0]     s2_sq_r  [3];
  logic              s3_v_r;
  logic [2:0]        s3_neg_r;
  logic [W-1:0]      s3_mag_r [3];
  logic [SW-1:0]     s3_sum_r;

  assign en       = !s3_v_r || !qstat.full;
  assign in_ready = en;
  assign push     = s3_v_r && !qstat.full;
  assign push_data = {s3_neg_r, s3_mag_r[2], s3_mag_r[1], s3_mag_r[0], s3_sum_r};

  // The most negative input has magnitude 2^(W-1), which still fits W bits.
  always_comb begin
    neg_nxt    = {in_comp_z[W-1], in_comp_y[W-1], in_comp_x[W-1]};
    abs_nxt[0] = in_comp_x[W-1] ? (~in_comp_x + W'(1)) : in_comp_x;
    abs_nxt[1] = in_comp_y[W-1] ? (~in_comp_y + W'(1)) : in_comp_y;
    abs_nxt[2] = in_comp_z[W-1] ? (~in_comp_z + W'(1)) : in_comp_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= neg_nxt;
      s2_neg_r <= s1_neg_r;
      s3_neg_r <= s2_neg_r;
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i] <= abs_nxt[i];
        s2_mag_r[i] <= s1_mag_r[i];
        s2_sq_r[i]  <= SW'(s1_mag_r[i]) * SW'(s1_mag_r[i]);
        s3_mag_r[i] <= s2_mag_r[i];
      end
      s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/v3n_fifo.sv =====
// ----------------------------------------------------------------------------
// v3n_fifo
// Short queue between the front and the back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_fifo #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output v3n_pkg::v3n_qstat_t    qstat
);

  logic [DATA_W-1:0]           mem_r [v3n_pkg::QUEUE_DEPTH];
  logic [v3n_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [v3n_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [v3n_pkg::QPTR_W:0]    count_r;
  logic [v3n_pkg::QPTR_W:0]    count_nxt;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == (v3n_pkg::QPTR_W+1)'(v3n_pkg::QUEUE_DEPTH));
  assign pop_data    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/v3n_back.sv =====
// ----------------------------------------------------------------------------
// v3n_back
// Square root, three-lane fractional divide, flush and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_back #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [3+5*COMP_WIDTH-1:0]           pop_data,
  input  wire v3n_pkg::v3n_qstat_t                 qstat,
  output logic                                     pop,
  input  wire logic [v3n_pkg::TOL_W-1:0]           tol,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [FRAC_BITS+1:0]              out_unit_x,
  output logic signed [FRAC_BITS+1:0]              out_unit_y,
  output logic signed [FRAC_BITS+1:0]              out_unit_z,
  output logic [COMP_WIDTH-1:0]                    out_magnitude,
  output logic                                     out_degenerate
);

  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * W;
  localparam int SQ = W;          // one root bit per stage
  localparam int DS = F + 1;      // one quotient bit per stage
  localparam int OW = F + 2;
  localparam int LW = W + F + v3n_pkg::TOL_W + 2;

  logic adv;

  // square root stages
  logic [SW-1:0]  c_rem  [SQ];
  logic [W-1:0]   c_root [SQ];
  logic [SW-1:0]  tst;
  logic [SW-1:0]  sq_rem_nxt  [SQ];
  logic [W-1:0]   sq_root_nxt [SQ];
  logic [SW-1:0]  sq_rem_r  [SQ];
  logic [W-1:0]   sq_root_r [SQ];
  logic [3*W-1:0] sq_mag_r  [SQ];
  logic [2:0]     sq_neg_r  [SQ];
  logic           sq_v_r    [SQ];

  // divide stages
  logic [W:0]     d_rem [DS][3];
  logic [F:0]     d_q   [DS][3];
  logic [W:0]     t;
  logic [W:0]     dv_rem_nxt [DS][3];
  logic [F:0]     dv_q_nxt   [DS][3];
  logic [W:0]     dv_rem_r [DS][3];
  logic [F:0]     dv_q_r   [DS][3];
  logic [3*W-1:0] dv_mag_r  [DS];
  logic [2:0]     dv_neg_r  [DS];
  logic [W-1:0]   dv_root_r [DS];
  logic           dv_v_r    [DS];

  // final
  logic           degen;
  logic [LW-1:0]  ql;
  logic [LW-1:0]  rl;
  logic [OW-1:0]  unit_nxt [3];

  assign adv = !out_valid || out_ready;
  assign pop = !qstat.empty && adv;

  // Each stage settles one root bit: accept it when the remainder covers
  // (2*root + 2^b) * 2^b, which is the growth of the square.
  always_comb begin
    c_rem[0]  = pop_data[SW-1:0];
    c_root[0] = '0;
    for (int k = 1; k < SQ; k++) begin
      c_rem[k]  = sq_rem_r[k-1];
      c_root[k] = sq_root_r[k-1];
    end
    tst = '0;
    for (int k = 0; k < SQ; k++) begin
      tst = ({{W{1'b0}}, c_root[k]} << (W - k)) | (SW'(1) << (2 * (W - 1 - k)));
      sq_rem_nxt[k]  = c_rem[k];
      sq_root_nxt[k] = c_root[k];
      if (c_rem[k] >= tst) begin
        sq_rem_nxt[k]  = c_rem[k] - tst;
        sq_root_nxt[k] = c_root[k] | (W'(1) << (W - 1 - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ; k++) begin
        sq_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      sq_v_r[0] <= !qstat.empty;
      for (int k = 1; k < SQ; k++) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_mag_r[0] <= pop_data[SW+3*W-1:SW];
      sq_neg_r[0] <= pop_data[SW+3*W+2:SW+3*W];
      for (int k = 1; k < SQ; k++) begin
        sq_mag_r[k] <= sq_mag_r[k-1];
        sq_neg_r[k] <= sq_neg_r[k-1];
      end
      for (int k = 0; k < SQ; k++) begin
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
      end
    end
  end

  // Restoring divide: the first stage takes the integer bit, the rest
  // shift the remainder and take one fraction bit each.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_rem[0][i] = {1'b0, sq_mag_r[SQ-1][i*W +: W]};
      d_q[0][i]   = '0;
    end
    for (int j = 1; j < DS; j++) begin
      for (int i = 0; i < 3; i++) begin
        d_rem[j][i] = dv_rem_r[j-1][i] << 1;
        d_q[j][i]   = dv_q_r[j-1][i];
      end
    end
    t = '0;
    for (int j = 0; j < DS; j++) begin
      for (int i = 0; i < 3; i++) begin
        t = d_rem[j][i];
        dv_q_nxt[j][i] = d_q[j][i] << 1;
        if (t >= {1'b0, (j == 0) ? sq_root_r[SQ-1] : dv_root_r[(j == 0) ? 0 : j-1]}) begin
          t = t - {1'b0, (j == 0) ? sq_root_r[SQ-1] : dv_root_r[(j == 0) ? 0 : j-1]};
          dv_q_nxt[j][i] = (d_q[j][i] << 1) | (F+1)'(1);
        end
        dv_rem_nxt[j][i] = t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DS; j++) begin
        dv_v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ-1];
      for (int j = 1; j < DS; j++) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_mag_r[0]  <= sq_mag_r[SQ-1];
      dv_neg_r[0]  <= sq_neg_r[SQ-1];
      dv_root_r[0] <= sq_root_r[SQ-1];
      for (int j = 1; j < DS; j++) begin
        dv_mag_r[j]  <= dv_mag_r[j-1];
        dv_neg_r[j]  <= dv_neg_r[j-1];
        dv_root_r[j] <= dv_root_r[j-1];
      end
      for (int j = 0; j < DS; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= dv_rem_nxt[j][i];
          dv_q_r[j][i]   <= dv_q_nxt[j][i];
        end
      end
    end
  end

  // A degenerate vector passes its raw components; flushing applies either way.
  always_comb begin
    degen = LW'(dv_root_r[DS-1]) <= LW'(tol);
    ql    = '0;
    rl    = '0;
    for (int i = 0; i < 3; i++) begin
      ql = degen ? LW'(dv_mag_r[DS-1][i*W +: W]) : LW'(dv_q_r[DS-1][i]);
      if (ql < LW'(tol)) begin
        ql = '0;
      end
      rl = dv_neg_r[DS-1][i] ? (~ql + LW'(1)) : ql;
      unit_nxt[i] = rl[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_unit_x     <= unit_nxt[0];
      out_unit_y     <= unit_nxt[1];
      out_unit_z     <= unit_nxt[2];
      out_magnitude  <= dv_root_r[DS-1];
      out_degenerate <= degen;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vector3_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes a signed fixed-point 3D vector and reports its magnitude.
// ----------------------------------------------------------------------------
//  Port group | Direction | Handshake           | Contents
//  in_        | input     | in_valid/in_ready   | comp_x, comp_y, comp_z
//  out_       | output    | out_valid/out_ready | unit_x/y/z, magnitude, degenerate
//  cfg_       | input     | cfg_wr_en           | tolerance
//
// One beat per cycle in and out while out_ready stays high.
// Path: front stages, queue, a square-root stage per root bit, a divide stage
// per quotient bit, output register. A stalled output freezes the back
// pipeline; the front keeps filling the four-entry queue until it is full.
// Reset clears valids, queue pointers and count, loads TOL_RESET; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COMP_WIDTH-1:0]      in_comp_x,
  input  wire logic signed [COMP_WIDTH-1:0]      in_comp_y,
  input  wire logic signed [COMP_WIDTH-1:0]      in_comp_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [FRAC_BITS+1:0]            out_unit_x,
  output logic signed [FRAC_BITS+1:0]            out_unit_y,
  output logic signed [FRAC_BITS+1:0]            out_unit_z,
  output logic [COMP_WIDTH-1:0]                  out_magnitude,
  output logic                                   out_degenerate,
  input  wire logic                              cfg_wr_en,
  input  wire logic [v3n_pkg::TOL_W-1:0]         cfg_wr_data
);

  localparam int EW = 3 + 5 * COMP_WIDTH;

  logic [v3n_pkg::TOL_W-1:0] tol_r;
  logic                      push;
  logic                      pop;
  logic [EW-1:0]             push_data;
  logic [EW-1:0]             pop_data;
  v3n_pkg::v3n_qstat_t       qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= v3n_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  v3n_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_comp_x (in_comp_x),
    .in_comp_y (in_comp_y),
    .in_comp_z (in_comp_z),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  v3n_fifo #(.DATA_W(EW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  v3n_back #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_data       (pop_data),
    .qstat          (qstat),
    .pop            (pop),
    .tol            (tol_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_unit_x     (out_unit_x),
    .out_unit_y     (out_unit_y),
    .out_unit_z     (out_unit_z),
    .out_magnitude  (out_magnitude),
    .out_degenerate (out_degenerate)
  );

endmodule

`default_nettype wire

// ===== rtl/v3n_checker.sv =====
// ----------------------------------------------------------------------------
// v3n_checker
// Port-level checks on the result channel of the vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module v3n_checker #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [FRAC_BITS+1:0]  out_unit_x,
  input wire logic signed [FRAC_BITS+1:0]  out_unit_y,
  input wire logic signed [FRAC_BITS+1:0]  out_unit_z,
  input wire logic [COMP_WIDTH-1:0]        out_magnitude,
  input wire logic                         out_degenerate
);

  localparam int signed UMAX = 1 << FRAC_BITS;

  logic unit_in_range;
  logic stalled;
  logic live_beat;

  assign stalled   = out_valid && !out_ready;
  assign live_beat = out_valid && !out_degenerate;

  assign unit_in_range =
    (int'(out_unit_x) <= UMAX) && (int'(out_unit_x) >= -UMAX) &&
    (int'(out_unit_y) <= UMAX) && (int'(out_unit_y) >= -UMAX) &&
    (int'(out_unit_z) <= UMAX) && (int'(out_unit_z) >= -UMAX);

  `V3N_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `V3N_ASSERT(a_hold_valid, clk, rst_n, stalled |=> out_valid, "beat dropped")
  `V3N_ASSERT(a_hold_mag, clk, rst_n, stalled |=> $stable(out_magnitude), "magnitude moved")
  `V3N_ASSERT(a_nonzero_mag, clk, rst_n, live_beat |-> out_magnitude != '0, "zero magnitude")
  `V3N_ASSERT(a_unit_range, clk, rst_n, live_beat |-> unit_in_range, "unit beyond one")

endmodule

bind vector3_normalize v3n_checker #(
  .COMP_WIDTH(COMP_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_v3n_checker (.*);

`default_nettype wire

// ===== sim/vector3_normalize_tb.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_tb
// Drives random and corner-case vectors through the normalizer, predicts the
// unit vector, magnitude and degenerate flag of each one, and checks every
// output beat in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector3_normalize_tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int PIPE_LAT = 3 + 1 + CW + FB + 1 + 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [FB+1:0] ux;
    logic signed [FB+1:0] uy;
    logic signed [FB+1:0] uz;
    logic [CW-1:0]        mag;
    logic                 degen;
  } norm_result_t;

  class norm_scoreboard;
    norm_result_t pending[$];
    logic [15:0]  tol;
    int           errors;

    function new();
      tol = v3n_pkg::TOL_RESET;
      errors = 0;
    endfunction

    // Floor square root of a 66-bit sum, one root bit at a time.
    function logic [CW-1:0] floor_sqrt(logic [2*CW+1:0] sum);
      logic [CW-1:0]    root;
      logic [CW-1:0]    cand;
      logic [2*CW+1:0]  sq;
      root = '0;
      for (int b = CW - 1; b >= 0; b--) begin
        cand = root | (CW'(1) << b);
        sq = {{(CW+2){1'b0}}, cand} * {{(CW+2){1'b0}}, cand};
        if (sq <= sum) root = cand;
      end
      return root;
    endfunction

    function void note_vector(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                              logic signed [CW-1:0] cz);
      logic signed [CW-1:0] comp[3];
      logic [CW:0]          amag[3];
      logic [2*CW+1:0]      sum;
      logic [CW-1:0]        m;
      logic [CW+FB:0]       q;
      logic [FB+1:0]        u[3];
      norm_result_t         r;
      comp[0] = cx; comp[1] = cy; comp[2] = cz;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        amag[i] = comp[i][CW-1] ? -{comp[i][CW-1], comp[i]} : {1'b0, comp[i]};
        sum += {{(CW+1){1'b0}}, amag[i]} * {{(CW+1){1'b0}}, amag[i]};
      end
      m = floor_sqrt(sum);
      r.degen = (m <= {16'd0, tol});
      for (int i = 0; i < 3; i++) begin
        if (r.degen) q = (CW+FB+1)'(amag[i]);
        else q = ((CW+FB+1)'(amag[i]) << FB) / (CW+FB+1)'(m);
        if (q < (CW+FB+1)'(tol)) q = '0;
        u[i] = comp[i][CW-1] ? -q[FB+1:0] : q[FB+1:0];
      end
      r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
      r.mag = m;
      pending.push_back(r);
    endfunction

    function void check_result(norm_result_t act);
      norm_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat, unit=(%0d,%0d,%0d) mag=%0d",
                 $time, act.ux, act.uy, act.uz, act.mag);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.ux !== exp_r.ux) begin
        $display("%0t: unit_x expected %0d actual %0d", $time, exp_r.ux, act.ux);
        errors++;
      end
      if (act.uy !== exp_r.uy) begin
        $display("%0t: unit_y expected %0d actual %0d", $time, exp_r.uy, act.uy);
        errors++;
      end
      if (act.uz !== exp_r.uz) begin
        $display("%0t: unit_z expected %0d actual %0d", $time, exp_r.uz, act.uz);
        errors++;
      end
      if (act.mag !== exp_r.mag) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, exp_r.mag, act.mag);
        errors++;
      end
      if (act.degen !== exp_r.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, exp_r.degen,
                 act.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_comp_x, in_comp_y, in_comp_z;
  logic out_valid;
  logic out_ready;
  logic signed [FB+1:0] out_unit_x, out_unit_y, out_unit_z;
  logic [CW-1:0] out_magnitude;
  logic out_degenerate;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  norm_scoreboard sb;
  int cycles;
  bit sink_on;

  vector3_normalize #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_magnitude(out_magnitude), .out_degenerate(out_degenerate),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input-side acceptance and the output monitor share the same sampled edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_vector(in_comp_x, in_comp_y, in_comp_z);
      if (out_valid && out_ready) begin
        norm_result_t r;
        r.ux = out_unit_x; r.uy = out_unit_y; r.uz = out_unit_z;
        r.mag = out_magnitude; r.degen = out_degenerate;
        sb.check_result(r);
      end
    end
  end

  // Output stall generator: random ready with quiet stretches and long holds.
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!sink_on) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z);
    in_valid  <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [15:0] t);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.tol = t;
    @(posedge clk);
  endtask

  function logic signed [CW-1:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return $urandom_range(0, 40) - 20;
      1: return $signed(CW'($urandom_range(0, 200000))) - 100000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'sh8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count);
    logic signed [CW-1:0] x, y, z;
    int p;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 9);
      x = rand_comp();
      y = rand_comp();
      z = rand_comp();
      // Some vectors lie on an axis or in a plane.
      if (p == 0) begin y = '0; z = '0; end
      if (p == 1) x = '0;
      send_vector(x, y, z);
      if ($urandom_range(0, 3) == 0) idle_input(gap_len());
    end
  endtask

  initial begin
    logic [15:0] tol_set[5];
    sb = new();
    sink_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_comp_x = '0; in_comp_y = '0; in_comp_z = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors at the reset tolerance, back to back.
    send_vector(0, 0, 0);
    send_vector(32'sh0001_0000, 0, 0);
    send_vector(0, -32'sh0001_0000, 0);
    send_vector(0, 0, 32'sh0001_0000);
    send_vector(7, 0, 0);
    send_vector(-7, 3, 2);
    send_vector(8, 0, 0);
    send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vector(32'sh8000_0000, 0, 0);
    send_vector(32'sh7FFF_FFFF, 1, -1);
    send_vector(32'sh0010_0000, 5, -5);
    send_vector(3, 4, 0);
    send_vector(-1, -1, -1);
    send_vector(32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA);
    drain();

    // Directed flush and degenerate cases at the largest tolerance.
    set_tolerance(16'hFFFF);
    send_vector(32'sh0000_FFFF, 0, 0);
    send_vector(32'sh0001_0000, 0, 0);
    send_vector(32'sh0000_8000, -32'sh0000_8000, 16);
    send_vector(32'sh0100_0000, 32'sh0001_0000, 0);
    send_vector(-32'sh0000_FFFE, 0, 1);
    drain();

    sink_on = 1'b1;
    tol_set[0] = 16'd0;
    tol_set[1] = v3n_pkg::TOL_RESET;
    tol_set[2] = 16'hFFFF;
    tol_set[3] = 16'h0100;
    tol_set[4] = 16'($urandom_range(1, 65534));
    for (int ph = 0; ph < 5; ph++) begin
      set_tolerance(tol_set[ph]);
      random_phase(270);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
